FILE: rtl/kmps_pkg.sv
package kmps_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int MAX_PATHS   = 8;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(MAX_PATHS + 1);
    localparam int ID_W   = 64;
    localparam int Q_W    = 17;
    localparam int PROD_W = 2 * Q_W;

    localparam logic [Q_W-1:0]    ONE_Q16  = 17'h10000;
    localparam logic [PROD_W-1:0] HALF_ACC = PROD_W'(32768);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_DEPTH - 1);

    typedef struct packed {
        logic [ID_W-1:0] emitter_id;
        logic            culled;
        logic            has_path;
        logic [Q_W-1:0]  diffraction;
        logic [Q_W-1:0]  transmission;
        logic            last_path;
        logic [Q_W-1:0]  blend;
    } kmps_in_t;

    typedef struct packed {
        logic [ID_W-1:0] out_emitter_id;
        logic [Q_W-1:0]  obstruction;
        logic [Q_W-1:0]  occlusion;
        logic            table_full;
    } kmps_out_t;

    typedef struct packed {
        logic [ID_W-1:0] key;
        logic [Q_W-1:0]  obs;
        logic [Q_W-1:0]  occ;
    } kmps_entry_t;

    typedef struct packed {
        logic [Q_W-1:0] s_obs;
        logic [Q_W-1:0] s_occ;
        logic [Q_W-1:0] t_obs;
        logic [Q_W-1:0] t_occ;
        logic [Q_W-1:0] b;
    } kmps_blend_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] obs;
        logic [Q_W-1:0] occ;
    } kmps_blend_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BLEND,
        ST_WRITE
    } kmps_state_t;

    function automatic logic [Q_W-1:0] clamp_one(input logic [Q_W-1:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

FILE: rtl/kmps_table_ram.sv
module kmps_table_ram (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [kmps_pkg::ADDR_W-1:0] wr_addr,
    input  kmps_pkg::kmps_entry_t       wr_data,
    input  logic                        rd_en,
    input  logic [kmps_pkg::ADDR_W-1:0] rd_addr,
    output kmps_pkg::kmps_entry_t       rd_data
);

    kmps_pkg::kmps_entry_t mem [kmps_pkg::TABLE_DEPTH];
    kmps_pkg::kmps_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/kmps_blend_unit.sv
module kmps_blend_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  kmps_pkg::kmps_blend_req_t  req,
    output kmps_pkg::kmps_blend_rsp_t  rsp
);

    kmps_pkg::kmps_blend_req_t        req_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [2:0]                       step_reg;
    logic [kmps_pkg::PROD_W-1:0]      prod_reg;
    logic [kmps_pkg::PROD_W-1:0]      acc_obs_reg;
    logic [kmps_pkg::PROD_W-1:0]      acc_occ_reg;
    logic [kmps_pkg::Q_W-1:0]         inv_b;
    logic [kmps_pkg::Q_W-1:0]         op_a;
    logic [kmps_pkg::Q_W-1:0]         op_m;

    assign inv_b = kmps_pkg::ONE_Q16 - req_reg.b;

    // one shared multiplier: s*(1-b) and t*b for each value in turn
    always_comb begin
        case (step_reg)
            3'd0:    op_a = req_reg.s_obs;
            3'd1:    op_a = req_reg.t_obs;
            3'd2:    op_a = req_reg.s_occ;
            default: op_a = req_reg.t_occ;
        endcase
        op_m = step_reg[0] ? req_reg.b : inv_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            req_reg <= req;
        end
        if (busy_reg) begin
            prod_reg <= kmps_pkg::PROD_W'(op_a) * kmps_pkg::PROD_W'(op_m);
            case (step_reg)
                3'd1:    acc_obs_reg <= kmps_pkg::HALF_ACC + prod_reg;
                3'd2:    acc_obs_reg <= acc_obs_reg + prod_reg;
                3'd3:    acc_occ_reg <= kmps_pkg::HALF_ACC + prod_reg;
                3'd4:    acc_occ_reg <= acc_occ_reg + prod_reg;
                default: ;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.obs  = acc_obs_reg[kmps_pkg::Q_W+15:16];
    assign rsp.occ  = acc_occ_reg[kmps_pkg::Q_W+15:16];

endmodule

FILE: rtl/keyed_min_path_smoother.sv
// Per-emitter obstruction/occlusion smoother. Path items that are not the
// last of an emitter fold into running minima. A last-path or culled item
// searches the keyed table through the single read port of the table
// memory, one entry per cycle. A last-path hit goes through the scan, the
// shared multiplier and write-back; a miss goes through the whole scan and
// write-back. A culled item stops at its key, or at the end of the table
// when the key is absent. The table's valid bits clear at reset, so no
// clearing pass is needed. A result sits in an output register and the
// write-back cycle waits only while a previous result has not been taken.
module keyed_min_path_smoother (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [63:0]           cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  kmps_pkg::kmps_in_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output kmps_pkg::kmps_out_t   m_data
);

    localparam int AW = kmps_pkg::ADDR_W;
    localparam int QW = kmps_pkg::Q_W;
    localparam int CW = kmps_pkg::CNT_W;

    kmps_pkg::kmps_state_t      state_reg, state_next;
    logic [63:0]                listener_reg;
    logic [QW-1:0]              min_d_reg, min_d_next;
    logic [QW-1:0]              min_t_reg, min_t_next;
    logic                       seen_reg, seen_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [63:0]                id_reg, id_next;
    logic                       culled_reg, culled_next;
    logic [QW-1:0]              blend_reg, blend_next;
    logic [QW-1:0]              tgt_obs_reg, tgt_obs_next;
    logic [QW-1:0]              tgt_occ_reg, tgt_occ_next;
    logic [AW:0]                issue_reg, issue_next;
    logic                       cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]              cmp_idx_reg, cmp_idx_next;
    logic                       free_found_reg, free_found_next;
    logic [AW-1:0]              free_idx_reg, free_idx_next;
    logic [AW-1:0]              wr_idx_reg, wr_idx_next;
    logic                       wr_flag_reg, wr_flag_next;
    logic                       full_reg, full_next;
    logic [QW-1:0]              res_obs_reg, res_obs_next;
    logic [QW-1:0]              res_occ_reg, res_occ_next;
    logic [kmps_pkg::TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                       m_valid_reg, m_valid_next;
    kmps_pkg::kmps_out_t        m_data_reg, m_data_next;

    // running minima including the item at the input
    logic [QW-1:0]              upd_d, upd_t;
    logic                       upd_seen;
    logic [CW-1:0]              upd_cnt;

    logic                       ram_wr_en, ram_rd_en;
    logic [AW-1:0]              ram_rd_addr;
    kmps_pkg::kmps_entry_t      ram_wr_data, ram_rd_data;
    logic                       blend_start;
    kmps_pkg::kmps_blend_req_t  blend_req;
    kmps_pkg::kmps_blend_rsp_t  blend_rsp;

    logic                       match, is_free, last_cmp;

    kmps_table_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    kmps_blend_unit u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (blend_start),
        .req     (blend_req),
        .rsp     (blend_rsp)
    );

    assign ram_wr_data.key = id_reg;
    assign ram_wr_data.obs = res_obs_reg;
    assign ram_wr_data.occ = res_occ_reg;

    assign blend_req.s_obs = ram_rd_data.obs;
    assign blend_req.s_occ = ram_rd_data.occ;
    assign blend_req.t_obs = tgt_obs_reg;
    assign blend_req.t_occ = tgt_occ_reg;
    assign blend_req.b     = blend_reg;

    assign match    = cmp_vld_reg && valid_reg[cmp_idx_reg] && (ram_rd_data.key == id_reg);
    assign is_free  = cmp_vld_reg && !valid_reg[cmp_idx_reg];
    assign last_cmp = cmp_vld_reg && (cmp_idx_reg == kmps_pkg::LAST_IDX);

    always_comb begin
        upd_d    = min_d_reg;
        upd_t    = min_t_reg;
        upd_seen = seen_reg;
        upd_cnt  = cnt_reg;
        if (s_data.has_path && (cnt_reg < CW'(kmps_pkg::MAX_PATHS))) begin
            upd_cnt  = cnt_reg + CW'(1);
            upd_seen = 1'b1;
            if (s_data.diffraction < min_d_reg) begin
                upd_d = s_data.diffraction;
            end
            if (s_data.transmission < min_t_reg) begin
                upd_t = s_data.transmission;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        min_d_next      = min_d_reg;
        min_t_next      = min_t_reg;
        seen_next       = seen_reg;
        cnt_next        = cnt_reg;
        id_next         = id_reg;
        culled_next     = culled_reg;
        blend_next      = blend_reg;
        tgt_obs_next    = tgt_obs_reg;
        tgt_occ_next    = tgt_occ_reg;
        issue_next      = issue_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        wr_idx_next     = wr_idx_reg;
        wr_flag_next    = wr_flag_reg;
        full_next       = full_reg;
        res_obs_next    = res_obs_reg;
        res_occ_next    = res_occ_reg;
        valid_next      = valid_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        s_ready         = 1'b0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = issue_reg[AW-1:0];
        blend_start     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            kmps_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && (s_data.emitter_id != listener_reg)) begin
                    id_next         = s_data.emitter_id;
                    culled_next     = s_data.culled;
                    blend_next      = (s_data.blend > kmps_pkg::ONE_Q16) ?
                                      kmps_pkg::ONE_Q16 : s_data.blend;
                    tgt_obs_next    = upd_seen ? upd_d : '0;
                    tgt_occ_next    = upd_seen ? upd_t : '0;
                    issue_next      = '0;
                    free_found_next = 1'b0;
                    if (s_data.culled || s_data.last_path) begin
                        min_d_next = kmps_pkg::ONE_Q16;
                        min_t_next = kmps_pkg::ONE_Q16;
                        seen_next  = 1'b0;
                        cnt_next   = '0;
                        state_next = kmps_pkg::ST_SCAN;
                    end else begin
                        min_d_next = upd_d;
                        min_t_next = upd_t;
                        seen_next  = upd_seen;
                        cnt_next   = upd_cnt;
                    end
                end
            end

            kmps_pkg::ST_SCAN: begin
                // read entry n while comparing entry n-1
                if (issue_reg < (AW+1)'(kmps_pkg::TABLE_DEPTH)) begin
                    ram_rd_en    = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[AW-1:0];
                    issue_next   = issue_reg + (AW+1)'(1);
                end
                if (is_free && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (match) begin
                    cmp_vld_next = 1'b0;
                    wr_idx_next  = cmp_idx_reg;
                    if (culled_reg) begin
                        valid_next[cmp_idx_reg] = 1'b0;
                        state_next = kmps_pkg::ST_IDLE;
                    end else begin
                        blend_start  = 1'b1;
                        wr_flag_next = 1'b1;
                        full_next    = 1'b0;
                        state_next   = kmps_pkg::ST_BLEND;
                    end
                end else if (last_cmp) begin
                    cmp_vld_next = 1'b0;
                    if (culled_reg) begin
                        state_next = kmps_pkg::ST_IDLE;
                    end else begin
                        // new emitter snaps to the target, lowest free entry
                        wr_flag_next = free_found_reg || is_free;
                        full_next    = !(free_found_reg || is_free);
                        wr_idx_next  = free_found_reg ? free_idx_reg : cmp_idx_reg;
                        res_obs_next = tgt_obs_reg;
                        res_occ_next = tgt_occ_reg;
                        state_next   = kmps_pkg::ST_WRITE;
                    end
                end
            end

            kmps_pkg::ST_BLEND: begin
                if (blend_rsp.done) begin
                    res_obs_next = blend_rsp.obs;
                    res_occ_next = blend_rsp.occ;
                    state_next   = kmps_pkg::ST_WRITE;
                end
            end

            kmps_pkg::ST_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    ram_wr_en = wr_flag_reg;
                    if (wr_flag_reg) begin
                        valid_next[wr_idx_reg] = 1'b1;
                    end
                    m_valid_next                = 1'b1;
                    m_data_next.out_emitter_id  = id_reg;
                    m_data_next.obstruction     = kmps_pkg::clamp_one(res_obs_reg);
                    m_data_next.occlusion       = kmps_pkg::clamp_one(res_occ_reg);
                    m_data_next.table_full      = full_reg;
                    state_next                  = kmps_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = kmps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= kmps_pkg::ST_IDLE;
            listener_reg <= '0;
            min_d_reg    <= kmps_pkg::ONE_Q16;
            min_t_reg    <= kmps_pkg::ONE_Q16;
            seen_reg     <= 1'b0;
            cnt_reg      <= '0;
            cmp_vld_reg  <= 1'b0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_wr_en) begin
                listener_reg <= cfg_wr_data;
            end
            min_d_reg    <= min_d_next;
            min_t_reg    <= min_t_next;
            seen_reg     <= seen_next;
            cnt_reg      <= cnt_next;
            cmp_vld_reg  <= cmp_vld_next;
            valid_reg    <= valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg         <= id_next;
        culled_reg     <= culled_next;
        blend_reg      <= blend_next;
        tgt_obs_reg    <= tgt_obs_next;
        tgt_occ_reg    <= tgt_occ_next;
        issue_reg      <= issue_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        wr_idx_reg     <= wr_idx_next;
        wr_flag_reg    <= wr_flag_next;
        full_reg       <= full_next;
        res_obs_reg    <= res_obs_next;
        res_occ_reg    <= res_occ_next;
        m_data_reg     <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/kmps_checker.sv
module kmps_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input kmps_pkg::kmps_out_t  m_data
);

    // no result may be pending right after reset
    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // reported values are clamped to 0..1
    a_values_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.obstruction <= kmps_pkg::ONE_Q16) &&
                    (m_data.occlusion <= kmps_pkg::ONE_Q16))
        else $error("smoothed value above 1.0");

endmodule

bind keyed_min_path_smoother kmps_checker u_kmps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
